### hw/rtl/i64div_pkg.sv
// shared constants, request codes and controller command type for the divider
package i64div_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [1:0] REQ_UQUO = 2'd0;
  localparam logic [1:0] REQ_UREM = 2'd1;
  localparam logic [1:0] REQ_SQUO = 2'd2;
  localparam logic [1:0] REQ_SREM = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } div_cmd_t;

endpackage

### hw/rtl/i64div_req_if.sv
// request channel: operation code and two 64-bit operands
interface i64div_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] dividend;
  logic [63:0] divisor;

  modport source (output valid, req_type, dividend, divisor, input ready);
  modport sink   (input valid, req_type, dividend, divisor, output ready);
endinterface

### hw/rtl/i64div_rsp_if.sv
// result channel: one 64-bit quotient or remainder
interface i64div_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

### hw/rtl/i64div_ctrl.sv
// divider controller: sequences load, shift-subtract steps and result write
module i64div_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i64div_pkg::div_cmd_t cmd
);
  import i64div_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIX
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  div_cmd_t           cmd_c;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd_c         = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_c.load = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_c.step = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        // output register free, or emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd_c.finish  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd       = cmd_c;

endmodule

### hw/rtl/i64div_dp.sv
// divider datapath: operand magnitudes, restoring divide step, sign fixup
module i64div_dp (
  input  logic                 clk,
  input  i64div_pkg::div_cmd_t cmd,
  input  logic [1:0]           in_req_type,
  input  logic [63:0]          in_dividend,
  input  logic [63:0]          in_divisor,
  output logic [63:0]          out_result
);
  import i64div_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          neg_q_r, neg_q_nxt;
  logic          neg_rm_r, neg_rm_nxt;
  logic          is_rem_r, is_rem_nxt;
  logic          dz_r, dz_nxt;
  logic [63:0]   result_r, result_nxt;

  logic [DW-1:0] n_in, d_in, n_mag, d_mag;
  logic          sgn_op, is_rem_req;
  logic [DW:0]   shifted, diff;
  logic          ge;
  logic [DW-1:0] sel_val, fix_val;
  logic          sel_neg;

  always_comb begin
    n_in       = in_dividend[DW-1:0];
    d_in       = in_divisor[DW-1:0];
    sgn_op     = (in_req_type == REQ_SQUO) || (in_req_type == REQ_SREM);
    is_rem_req = (in_req_type == REQ_UREM) || (in_req_type == REQ_SREM);
    n_mag      = (sgn_op && n_in[DW-1]) ? (~n_in + 1'b1) : n_in;
    d_mag      = (sgn_op && d_in[DW-1]) ? (~d_in + 1'b1) : d_in;

    // one restoring step: shift in the next dividend bit, try the subtract
    shifted = {rem_r, quo_r[DW-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = !diff[DW];

    sel_val = is_rem_r ? rem_r : quo_r;
    sel_neg = is_rem_r ? neg_rm_r : neg_q_r;
    fix_val = sel_neg ? (~sel_val + 1'b1) : sel_val;

    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    den_nxt    = den_r;
    neg_q_nxt  = neg_q_r;
    neg_rm_nxt = neg_rm_r;
    is_rem_nxt = is_rem_r;
    dz_nxt     = dz_r;
    result_nxt = result_r;

    if (cmd.load) begin
      rem_nxt    = '0;
      quo_nxt    = n_mag;
      den_nxt    = d_mag;
      neg_q_nxt  = sgn_op && (n_in[DW-1] ^ d_in[DW-1]);
      neg_rm_nxt = sgn_op && n_in[DW-1];
      is_rem_nxt = is_rem_req;
      dz_nxt     = (d_in == '0);
    end
    if (cmd.step) begin
      rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
    end
    if (cmd.finish) begin
      result_nxt = dz_r ? 64'd0 : 64'(fix_val);
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    den_r    <= den_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_rm_r <= neg_rm_nxt;
    is_rem_r <= is_rem_nxt;
    dz_r     <= dz_nxt;
    result_r <= result_nxt;
  end

  assign out_result = result_r;

endmodule

### hw/rtl/int64_divider.sv
// top level of the 64-bit integer divider
// Divides a 64-bit dividend by a 64-bit divisor and returns the unsigned or
// signed quotient or remainder, selected by req_type. Signed results truncate
// toward zero, the remainder takes the sign of the dividend, the most negative
// value divided by -1 wraps to itself, and a zero divisor returns 0. One request
// is in work at a time. The operand magnitudes are loaded in the cycle the
// request is accepted, then one quotient bit is formed per cycle in the
// shift-subtract loop, then a sign fixup step writes the result register and
// presents it. The controller then returns to idle, so a new request is taken
// only once the previous one has reached the output register. A finished
// result waits in the output register while the next request is accepted and
// divided; the divider stalls at the fixup step only if that register is still
// occupied.
module int64_divider (
  input logic         clk,
  input logic         rst_n,
  i64div_req_if.sink  in_req,
  i64div_rsp_if.source out_rsp
);
  import i64div_pkg::*;

  div_cmd_t cmd;

  i64div_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  i64div_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_req_type (in_req.req_type),
    .in_dividend (in_req.dividend),
    .in_divisor  (in_req.divisor),
    .out_result  (out_rsp.result)
  );

  // a request in work blocks the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("input ready while a request is in work");

  // writing the result register always presents it
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_rsp.valid)
    else $error("result written but not presented");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_rsp.valid || out_rsp.ready))
    else $error("result register overwritten");

  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule
